/* rtl/slsm_pkg.sv */
`timescale 1ns / 1ps

package slsm_pkg;

	localparam int MOVE_W  = 16;
	localparam int SCORE_W = 32;
	localparam int ENTRY_W = MOVE_W + SCORE_W;

	// action codes carried on the input tuser
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_PICK   = 2'd2;

	// scores are stored offset-binary so an unsigned compare orders them
	localparam logic [SCORE_W-1:0] SIGN_BIAS    = 32'h8000_0000;
	localparam logic [SCORE_W-1:0] FLOOR_BIASED = 32'h0000_0001;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic init;
		logic sample;
		logic first;
	} best_ctl_t;

endpackage

/* rtl/scored_list_select_max.sv */
// Clear and append transactions give no result.
// A pick scans the live entries, reading one entry per cycle through the single
// read port of the entry memory; after the DRAIN state, the SWAP_A and SWAP_B
// states swap the chosen entry into the last live slot before the result is emitted.
// A pick on an empty list goes straight to the result without a scan; a new
// transaction is taken the cycle after the result is registered. Reset clears the live count and the sequencer; the entry memory is not cleared.
`timescale 1ns / 1ps

module scored_list_select_max #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] move_code, [47:16] move_score
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] picked_move
	output logic [1:0]  m_tuser    // [0] found, [1] list_empty
);
	import slsm_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t state_q, state_d;

	// entry memory: {biased score, move}
	logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_dec;
	logic [AW-1:0]      last_idx;
	logic               full;
	logic               accept;
	logic               out_free;

	logic [AW-1:0]      scan_idx_q;
	logic               rd_en;
	logic               rd_valid_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic [ENTRY_W-1:0] rd_data_s1;

	logic [MOVE_W-1:0]  last_move_q;
	logic [SCORE_W-1:0] last_score_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	best_ctl_t          best_ctl;
	logic [AW-1:0]      sel_idx;
	logic [MOVE_W-1:0]  sel_move;
	logic [SCORE_W-1:0] sel_score;
	logic               hit;

	logic [MOVE_W-1:0]  res_move_q;
	logic               res_found_q;
	logic               res_empty_q;

	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	assign count_dec = count_q - CW'(1);
	assign last_idx  = count_dec[AW-1:0];
	assign full      = (count_q == CW'(MAX_ENTRIES));
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// ---------------------------------------------------------------
	// sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tuser == ACT_PICK) begin
					state_d = (count_q == '0) ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_SWAP_A;
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// sequencer: outputs (handshake, memory port, compare unit control)
	// ---------------------------------------------------------------
	always_comb begin
		s_tready      = 1'b0;
		rd_en         = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = '0;
		wr_data       = '0;
		best_ctl.init = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// append writes at the current fill position; drop when full
				if (s_tvalid && s_tuser == ACT_APPEND && !full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = {s_tdata[47:16] ^ SIGN_BIAS, s_tdata[15:0]};
				end
				if (s_tvalid && s_tuser == ACT_PICK && count_q != '0) begin
					best_ctl.init = 1'b1;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_SWAP_A: begin
				// move the last live entry into the chosen slot
				wr_en   = 1'b1;
				wr_addr = sel_idx;
				wr_data = {last_score_q, last_move_q};
			end
			ST_SWAP_B: begin
				// park the chosen entry in the last live slot
				wr_en   = 1'b1;
				wr_addr = last_idx;
				wr_data = {sel_score, sel_move};
			end
			default: begin
			end
		endcase
		best_ctl.sample = rd_valid_s1;
		best_ctl.first  = (rd_idx_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// entry memory: one write port, one registered read port
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[scan_idx_q];
		end
		rd_idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	// ---------------------------------------------------------------
	// live count and scan address
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
		end else begin
			if (state_q == ST_IDLE) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end

			if (accept && s_tuser == ACT_CLEAR) begin
				count_q <= '0;
			end else if (accept && s_tuser == ACT_APPEND && !full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == ST_SWAP_B) begin
				count_q <= count_dec;
			end
		end
	end

	// hold the last live entry as it passes by during the scan
	always_ff @(posedge clk) begin
		if (rd_valid_s1 && rd_idx_s1 == last_idx) begin
			last_move_q  <= rd_data_s1[MOVE_W-1:0];
			last_score_q <= rd_data_s1[ENTRY_W-1:MOVE_W];
		end
	end

	// ---------------------------------------------------------------
	// shared compare unit: running maximum over the scan
	// ---------------------------------------------------------------
	slsm_best #(
		.AW (AW)
	) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (best_ctl),
		.smp_idx   (rd_idx_s1),
		.smp_move  (rd_data_s1[MOVE_W-1:0]),
		.smp_score (rd_data_s1[ENTRY_W-1:MOVE_W]),
		.sel_idx   (sel_idx),
		.sel_move  (sel_move),
		.sel_score (sel_score),
		.hit       (hit)
	);

	// ---------------------------------------------------------------
	// result staging and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && s_tuser == ACT_PICK && count_q == '0) begin
			res_move_q  <= '0;
			res_found_q <= 1'b0;
			res_empty_q <= 1'b1;
		end else if (state_q == ST_SWAP_B) begin
			res_move_q  <= hit ? sel_move : '0;
			res_found_q <= hit;
			res_empty_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= res_move_q;
			m_tuser_q <= {res_empty_q, res_found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("live count above capacity");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> count_q != '0)
		else $error("scan started on an empty list");

	a_swap_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWAP_B |=> count_q == CW'($past(count_q) - CW'(1)))
		else $error("pick did not shrink the live count");

	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ACT_PICK && count_q == '0) |=> state_q == ST_EMIT)
		else $error("empty-list pick did not go straight to result");
`endif

endmodule

/* rtl/slsm_best.sv */
`timescale 1ns / 1ps

module slsm_best #(
	parameter int AW = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slsm_pkg::best_ctl_t          ctl,
	input  logic [AW-1:0]                smp_idx,
	input  logic [slsm_pkg::MOVE_W-1:0]  smp_move,
	input  logic [slsm_pkg::SCORE_W-1:0] smp_score,
	output logic [AW-1:0]                sel_idx,
	output logic [slsm_pkg::MOVE_W-1:0]  sel_move,
	output logic [slsm_pkg::SCORE_W-1:0] sel_score,
	output logic                         hit
);
	import slsm_pkg::*;

	logic [SCORE_W-1:0] best_q;
	logic               hit_q;
	logic [AW-1:0]      sel_idx_q;
	logic [MOVE_W-1:0]  sel_move_q;
	logic [SCORE_W-1:0] sel_score_q;
	logic               take;

	// strictly greater keeps the first of equal scores
	assign take = smp_score > best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= FLOOR_BIASED;
			hit_q  <= 1'b0;
		end else if (ctl.init) begin
			best_q <= FLOOR_BIASED;
			hit_q  <= 1'b0;
		end else if (ctl.sample && take) begin
			best_q <= smp_score;
			hit_q  <= 1'b1;
		end
	end

	// slot 0 is the fallback choice when nothing beats the floor
	always_ff @(posedge clk) begin
		if (ctl.sample && (take || ctl.first)) begin
			sel_idx_q   <= smp_idx;
			sel_move_q  <= smp_move;
			sel_score_q <= smp_score;
		end
	end

	assign sel_idx   = sel_idx_q;
	assign sel_move  = sel_move_q;
	assign sel_score = sel_score_q;
	assign hit       = hit_q;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for scored_list_select_max.
// A queue of list operations (clear, append, pick and the unused action code)
// is built at time zero and fed to the slave stream by a clocked driver. A
// shadow copy of the move list predicts every pick at its acceptance. The
// master-stream monitor compares each result against the oldest prediction.
module testbench;
	import slsm_pkg::*;

	localparam int LIST_DEPTH  = 256;
	localparam int ITEM_TARGET = 1350;
	localparam int TAIL_ITEMS  = 120;
	localparam int CYCLE_LIMIT = 2_000_000;
	// action code that the block must ignore
	localparam logic [1:0] ACT_IGNORED = 2'd3;
	// raw two's-complement score values of interest
	localparam logic [31:0] SCORE_MIN   = 32'h8000_0000;
	localparam logic [31:0] SCORE_FLOOR = 32'h8000_0001;
	localparam logic [31:0] SCORE_ABOVE = 32'h8000_0002;
	localparam logic [31:0] SCORE_MAX   = 32'h7fff_ffff;

	typedef struct {
		logic [1:0]  act;
		logic [15:0] code;
		logic [31:0] score;
	} list_op_t;

	typedef struct {
		logic [15:0] move;
		logic        found;
		logic        empty;
	} pick_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // [15:0] move_code, [47:16] move_score
	logic [1:0]  s_tuser = ACT_CLEAR;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;   // [15:0] picked_move
	logic [1:0]  m_tuser;   // [0] found, [1] list_empty

	list_op_t     op_q[$];
	pick_result_t pending_picks[$];

	// shadow of the list; scores kept offset-binary like the block does
	logic [15:0] shadow_moves[LIST_DEPTH];
	logic [31:0] shadow_scores[LIST_DEPTH];
	int          shadow_live = 0;

	int  op_total = 0;
	int  gen_count = 0;
	int  ops_accepted = 0;
	int  err_count = 0;
	int  cycle_count = 0;
	logic in_taken = 1'b0;

	int  src_gap = 0;
	int  src_calm = 0;
	int  sink_gap = 0;
	int  sink_calm = 0;

	scored_list_select_max #(
		.MAX_ENTRIES(LIST_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Advance the shadow list by one accepted transaction; queue the result of a pick.
	function automatic void list_apply(input logic [1:0] act, input logic [15:0] code,
			input logic [31:0] score);
		logic [31:0]  best;
		logic [15:0]  tm;
		logic [31:0]  ts;
		int           idx;
		int           last;
		pick_result_t res;
		case (act)
			ACT_CLEAR: begin
				// drop the count only; stale entries stay in the store
				shadow_live = 0;
			end
			ACT_APPEND: begin
				// an append to a full list is dropped silently
				if (shadow_live < LIST_DEPTH) begin
					shadow_moves[shadow_live] = code;
					shadow_scores[shadow_live] = score ^ SIGN_BIAS;
					shadow_live++;
				end
			end
			ACT_PICK: begin
				if (shadow_live == 0) begin
					res = '{move: 16'h0000, found: 1'b0, empty: 1'b1};
				end else begin
					best = FLOOR_BIASED;
					idx = 0;
					res = '{move: 16'h0000, found: 1'b0, empty: 1'b0};
					// first strictly higher score wins; ties keep the earlier slot
					for (int i = 0; i < shadow_live; i++) begin
						if (shadow_scores[i] > best) begin
							best = shadow_scores[i];
							res.move = shadow_moves[i];
							res.found = 1'b1;
							idx = i;
						end
					end
					// swap the chosen slot (slot 0 when nothing beat the floor) to the end
					last = shadow_live - 1;
					tm = shadow_moves[idx];
					ts = shadow_scores[idx];
					shadow_moves[idx] = shadow_moves[last];
					shadow_scores[idx] = shadow_scores[last];
					shadow_moves[last] = tm;
					shadow_scores[last] = ts;
					shadow_live = last;
				end
				pending_picks.insert(pending_picks.size(), res);
			end
			default: begin
				// unused action: no result, no state change
			end
		endcase
	endfunction

	function automatic void push_op(input logic [1:0] act, input logic [15:0] code,
			input logic [31:0] score);
		list_op_t op;
		op = '{act: act, code: code, score: score};
		op_q.insert(op_q.size(), op);
		op_total++;
		if (act != ACT_IGNORED)
			gen_count++;
	endfunction

	// Bias scores toward the floor, the extremes and small values that tie.
	function automatic logic [31:0] rand_score();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = SCORE_MIN;
			1: v = SCORE_FLOOR;
			2: v = SCORE_ABOVE;
			3: v = SCORE_MAX;
			4, 5: v = 32'($urandom_range(0, 6)) - 32'd3;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Build the whole stimulus, release reset, then wait for the list to drain.
	initial begin
		int n;
		int k;
		int r;

		// directed part: empty pick, floor cases, ties, extremes, clear, unused action
		push_op(ACT_PICK, 16'h0000, 32'h0);
		push_op(ACT_IGNORED, 16'hffff, 32'hffff_ffff);
		push_op(ACT_APPEND, 16'hffff, SCORE_MIN);
		push_op(ACT_APPEND, 16'h0000, SCORE_FLOOR);
		push_op(ACT_PICK, 16'h0000, 32'h0);   // nothing beats the floor
		push_op(ACT_PICK, 16'h0000, 32'h0);
		push_op(ACT_PICK, 16'h0000, 32'h0);   // empty again
		push_op(ACT_APPEND, 16'h1234, 32'd5);
		push_op(ACT_APPEND, 16'h5678, 32'd5);   // tie: earlier entry wins
		push_op(ACT_APPEND, 16'ha5a5, SCORE_MAX);
		push_op(ACT_APPEND, 16'h5a5a, 32'hffff_ffff);
		push_op(ACT_IGNORED, 16'h0000, 32'h0);
		push_op(ACT_PICK, 16'h0000, 32'h0);
		push_op(ACT_PICK, 16'h0000, 32'h0);
		push_op(ACT_PICK, 16'h0000, 32'h0);
		push_op(ACT_CLEAR, 16'h0000, 32'h0);
		push_op(ACT_PICK, 16'h0000, 32'h0);   // clear leaves stale entries unreachable
		push_op(ACT_APPEND, 16'h0001, SCORE_ABOVE);
		push_op(ACT_APPEND, 16'h8000, 32'h0);
		push_op(ACT_CLEAR, 16'hffff, 32'hffff_ffff);
		push_op(ACT_APPEND, 16'h00ff, SCORE_MAX);
		push_op(ACT_PICK, 16'h0000, 32'h0);
		push_op(ACT_PICK, 16'h0000, 32'h0);

		// fill the list past its depth so appends to a full list get dropped
		push_op(ACT_CLEAR, 16'($urandom), $urandom);
		for (int i = 0; i < LIST_DEPTH + 2; i++)
			push_op(ACT_APPEND, 16'($urandom), rand_score());
		push_op(ACT_PICK, 16'($urandom), $urandom);
		push_op(ACT_PICK, 16'($urandom), $urandom);
		for (int i = 0; i < 3; i++)
			push_op(ACT_APPEND, 16'($urandom), rand_score());
		for (int i = 0; i < 4; i++)
			push_op(ACT_PICK, 16'($urandom), $urandom);

		// random part: mostly fill-then-pick episodes, some raw noise
		while (gen_count < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					push_op(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
			end else begin
				if ($urandom_range(0, 1) == 0)
					push_op(ACT_CLEAR, 16'($urandom), $urandom);
				n = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 260) :
					$urandom_range(1, 16);
				for (int i = 0; i < n; i++)
					push_op(ACT_APPEND, 16'($urandom), rand_score());
				k = (n > 16) ? $urandom_range(1, 12) : $urandom_range(1, n + 2);
				for (int i = 0; i < k; i++) begin
					if ($urandom_range(0, 5) == 0)
						push_op(ACT_APPEND, 16'($urandom), rand_score());
					if ($urandom_range(0, 19) == 0)
						push_op(ACT_IGNORED, 16'($urandom), $urandom);
					push_op(ACT_PICK, 16'($urandom), $urandom);
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (ops_accepted < op_total)
			@(negedge clk);
		while (pending_picks.size() != 0)
			@(negedge clk);
		// let a possible stray result show up: a full scan plus margin
		repeat (LIST_DEPTH + 20) @(negedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Slave-side driver: hold an offered transaction until taken, idle in bursts.
	always @(negedge clk) begin
		list_op_t op;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			// hold the offered transaction
		end else if (src_gap > 0) begin
			src_gap--;
			s_tvalid <= 1'b0;
		end else if (op_q.size() == 0) begin
			s_tvalid <= 1'b0;
		end else if (op_q.size() > TAIL_ITEMS && src_calm == 0 && $urandom_range(0, 7) == 0)
		begin
			src_gap = $urandom_range(1, 11) - 1;
			src_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
			s_tvalid <= 1'b0;
		end else begin
			if (src_calm > 0)
				src_calm--;
			op = op_q.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= {op.score, op.code};
			s_tuser <= op.act;
		end
	end

	// Master-side stall generator; no stalls once the stimulus is nearly done.
	always @(negedge clk) begin
		if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (op_q.size() > TAIL_ITEMS && sink_calm == 0 && $urandom_range(0, 7) == 0)
		begin
			sink_gap = $urandom_range(1, 11) - 1;
			sink_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
			m_tready <= 1'b0;
		end else begin
			if (sink_calm > 0)
				sink_calm--;
			m_tready <= 1'b1;
		end
	end

	// Monitor: predict on input transactions, check output transactions.
	always @(posedge clk) begin
		pick_result_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			list_apply(s_tuser, s_tdata[15:0], s_tdata[47:16]);
			ops_accepted++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_picks.size() == 0) begin
				report_mismatch($sformatf("result with no pick pending: move %h user %b",
					m_tdata, m_tuser));
			end else begin
				want = pending_picks.pop_front();
				if (m_tdata !== want.move)
					report_mismatch($sformatf("picked_move %h, want %h", m_tdata, want.move));
				if (m_tuser[0] !== want.found)
					report_mismatch($sformatf("found %b, want %b", m_tuser[0], want.found));
				if (m_tuser[1] !== want.empty)
					report_mismatch($sformatf("list_empty %b, want %b", m_tuser[1],
						want.empty));
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
